>>> sv/assert_macros.svh
// Assertion macros used by the top RTL file of the neighbor virial accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define NVA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication outside reset
`define NVA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/nva_pkg.sv
// Package for the neighbor virial accumulator: sizes, codes, types and helpers.
`default_nettype none

package nva_pkg;

    // Store geometry
    localparam int MAX_ATOMS = 1024;
    localparam int ATOM_AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int NSLOT     = 9;
    localparam int NAXIS     = 3;
    localparam int VIR_W     = 64;
    localparam int ROW_W     = NSLOT * VIR_W;
    localparam int CNT_W     = 17;
    localparam logic [CNT_W-1:0] MAX_ATOMS_V = CNT_W'(MAX_ATOMS);

    // Saturation limits, Q32.32
    localparam logic [VIR_W-1:0] VMAX = {1'b0, {(VIR_W-1){1'b1}}};
    localparam logic [VIR_W-1:0] VMIN = {1'b1, {(VIR_W-1){1'b0}}};

    // Request codes
    localparam logic [1:0] REQ_ACC   = 2'd0;
    localparam logic [1:0] REQ_ATOM  = 2'd1;
    localparam logic [1:0] REQ_TOTAL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NE,
        ST_LO,
        ST_HI,
        ST_SUM,
        ST_RND,
        ST_ADD,
        ST_WB,
        ST_RD,
        ST_EMIT
    } state_t;

    // Product unit steps
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_NE,
        STEP_LO,
        STEP_HI,
        STEP_SUM,
        STEP_RND
    } step_t;

    // Controls from the sequencer to the product unit
    typedef struct packed {
        logic       load;
        step_t      step;
        logic [1:0] b;
        logic [1:0] a;
    } prod_ctrl_t;

    // Signed 64-bit add with saturation
    function automatic logic [VIR_W-1:0] sat_add(input logic [VIR_W-1:0] x,
                                                 input logic [VIR_W-1:0] y);
        logic [VIR_W-1:0] s;
        s = x + y;
        if ((x[VIR_W-1] == y[VIR_W-1]) && (s[VIR_W-1] != x[VIR_W-1])) begin
            return x[VIR_W-1] ? VMIN : VMAX;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/nva_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module nva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/nva_product.sv
// Product unit: one shared 32x32 multiplier forming the rounded Q32.32 terms n*e*r.
`default_nettype none

module nva_product import nva_pkg::*; (
    input  wire logic               aclk,
    input  wire prod_ctrl_t         ctrl,
    input  wire logic signed [31:0] net_deriv_value,
    input  wire logic signed [31:0] env_x,
    input  wire logic signed [31:0] env_y,
    input  wire logic signed [31:0] env_z,
    input  wire logic signed [31:0] rel_x,
    input  wire logic signed [31:0] rel_y,
    input  wire logic signed [31:0] rel_z,
    output logic [VIR_W-1:0]        prod
);

    // Operand magnitudes and signs, captured at accept
    logic [31:0] n_mag_reg;
    logic        n_neg_reg;
    logic [31:0] e_mag_reg [NAXIS];
    logic        e_neg_reg [NAXIS];
    logic [31:0] r_mag_reg [NAXIS];
    logic        r_neg_reg [NAXIS];

    // Intermediate results
    logic [63:0] ne_mag_reg [NAXIS];
    logic        ne_neg_reg [NAXIS];
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [63:0] q_reg;
    logic        ovf_reg;
    logic        rem_reg;
    logic        neg_reg;
    logic [VIR_W-1:0] p_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [95:0] sum96;
    logic [VIR_W-1:0] p_next;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Shared multiplier operand select
    always_comb begin
        mul_a = ne_mag_reg[ctrl.b][31:0];
        mul_b = r_mag_reg[ctrl.a];
        case (ctrl.step)
            STEP_NE: begin
                mul_a = n_mag_reg;
                mul_b = e_mag_reg[ctrl.b];
            end
            STEP_HI: begin
                mul_a = ne_mag_reg[ctrl.b][63:32];
            end
            default: begin
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Combine the two partials of the Q48.48 product
    assign sum96 = {32'd0, plo_reg} + {phi_reg, 32'd0};

    // Floor to Q32.32 and saturate
    always_comb begin
        if (ovf_reg) begin
            p_next = neg_reg ? VMIN : VMAX;
        end else if (!neg_reg) begin
            p_next = q_reg[63] ? VMAX : q_reg;
        end else if (q_reg[63] || (rem_reg && (&q_reg[62:0]))) begin
            p_next = VMIN;
        end else begin
            // -(q + rem): rem set gives ~q, otherwise ~q + 1
            p_next = rem_reg ? ~q_reg : (~q_reg + 64'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            n_mag_reg    <= mag32(net_deriv_value);
            n_neg_reg    <= net_deriv_value[31];
            e_mag_reg[0] <= mag32(env_x);
            e_mag_reg[1] <= mag32(env_y);
            e_mag_reg[2] <= mag32(env_z);
            e_neg_reg[0] <= env_x[31];
            e_neg_reg[1] <= env_y[31];
            e_neg_reg[2] <= env_z[31];
            r_mag_reg[0] <= mag32(rel_x);
            r_mag_reg[1] <= mag32(rel_y);
            r_mag_reg[2] <= mag32(rel_z);
            r_neg_reg[0] <= rel_x[31];
            r_neg_reg[1] <= rel_y[31];
            r_neg_reg[2] <= rel_z[31];
        end
        case (ctrl.step)
            STEP_NE: begin
                ne_mag_reg[ctrl.b] <= mul_p;
                ne_neg_reg[ctrl.b] <= n_neg_reg ^ e_neg_reg[ctrl.b];
            end
            STEP_LO: begin
                plo_reg <= mul_p;
            end
            STEP_HI: begin
                phi_reg <= mul_p;
            end
            STEP_SUM: begin
                q_reg   <= sum96[79:16];
                ovf_reg <= |sum96[95:80];
                rem_reg <= |sum96[15:0];
                neg_reg <= ne_neg_reg[ctrl.b] ^ r_neg_reg[ctrl.a];
            end
            STEP_RND: begin
                p_reg <= p_next;
            end
            default: begin
            end
        endcase
    end

    assign prod = p_reg;

endmodule

`default_nettype wire

>>> sv/neighbor_virial_accumulator_top.sv
// Neighbor virial accumulator: sequencer, window check, accumulators and atom store.
// Accumulate in window: accept, 3 n*e steps, 9 slots x 5 steps of the shared multiplier and
//   rounding path, then 1 row write-back; a skipped word is taken in idle with no further steps.
// Read total: emit, then the output register; read atom in window adds a store read (RD) first.
// A new word is taken while a result waits; a read stalls in emit until the output frees.
// Reset (aresetn low, synchronous) clears total and config, then a clearing pass writes
//   zero to all MAX_ATOMS store rows, one per cycle, with s_ready low.
`default_nettype none

module neighbor_virial_accumulator_top import nva_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    // input words
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_req_type,
    input  wire logic signed [16:0]   s_neighbor_index,
    input  wire logic signed [31:0]   s_net_deriv_value,
    input  wire logic signed [31:0]   s_env_x,
    input  wire logic signed [31:0]   s_env_y,
    input  wire logic signed [31:0]   s_env_z,
    input  wire logic signed [31:0]   s_rel_x,
    input  wire logic signed [31:0]   s_rel_y,
    input  wire logic signed [31:0]   s_rel_z,
    // result words
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_in_window,
    output logic signed [63:0]        m_vir_0,
    output logic signed [63:0]        m_vir_1,
    output logic signed [63:0]        m_vir_2,
    output logic signed [63:0]        m_vir_3,
    output logic signed [63:0]        m_vir_4,
    output logic signed [63:0]        m_vir_5,
    output logic signed [63:0]        m_vir_6,
    output logic signed [63:0]        m_vir_7,
    output logic signed [63:0]        m_vir_8
);

    `include "assert_macros.svh"

    // Config registers
    logic [15:0] window_start_reg;
    logic [10:0] window_count_reg;

    // Control state
    state_t             state_reg, state_next;
    logic [1:0]         b_reg, b_next;
    logic [1:0]         a_reg, a_next;
    logic [3:0]         k_reg, k_next;
    logic [ATOM_AW-1:0] clr_reg, clr_next;
    logic [ATOM_AW-1:0] slot_reg;
    logic               emit_total_reg;
    logic               emit_win_reg;
    logic               m_valid_reg;

    // Data
    logic [VIR_W-1:0] total_reg [NSLOT];
    logic [VIR_W-1:0] row_reg   [NSLOT];
    logic [VIR_W-1:0] vir_reg   [NSLOT];
    logic             in_window_reg;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic               in_win;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W-1:0]   diff;
    logic [ATOM_AW-1:0] win_slot;
    logic               ram_we;
    logic [ATOM_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ROW_W-1:0]   ram_rdata;
    logic [VIR_W-1:0]   prod;
    prod_ctrl_t         pc;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    // Window test: non-negative, at or above start, offset below capped count
    assign cnt_eff  = ({6'd0, window_count_reg} > MAX_ATOMS_V) ? MAX_ATOMS_V
                                                               : {6'd0, window_count_reg};
    assign diff     = {1'b0, s_neighbor_index[15:0]} - {1'b0, window_start_reg};
    assign in_win   = !s_neighbor_index[16] && !diff[16] && (diff < cnt_eff);
    assign win_slot = diff[ATOM_AW-1:0];

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= 16'd0;
            window_count_reg <= 11'd1024;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START: window_start_reg <= cfg_wdata;
                CFG_COUNT: window_count_reg <= cfg_wdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: next state and controls
    always_comb begin
        state_next = state_reg;
        b_next     = b_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        s_ready    = 1'b0;
        ram_re     = 1'b0;
        pc.load    = 1'b0;
        pc.step    = STEP_NONE;
        pc.b       = b_reg;
        pc.a       = a_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ATOM_AW'(MAX_ATOMS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                pc.load = s_valid;
                b_next  = 2'd0;
                a_next  = 2'd0;
                k_next  = 4'd0;
                if (s_valid) begin
                    case (s_req_type)
                        REQ_ACC: begin
                            ram_re = in_win;
                            if (in_win) begin
                                state_next = ST_NE;
                            end
                        end
                        REQ_ATOM: begin
                            ram_re     = in_win;
                            state_next = in_win ? ST_RD : ST_EMIT;
                        end
                        REQ_TOTAL: begin
                            state_next = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NE: begin
                pc.step = STEP_NE;
                if (b_reg == 2'd2) begin
                    b_next     = 2'd0;
                    state_next = ST_LO;
                end else begin
                    b_next = b_reg + 2'd1;
                end
            end
            ST_LO: begin
                pc.step    = STEP_LO;
                state_next = ST_HI;
            end
            ST_HI: begin
                pc.step    = STEP_HI;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                pc.step    = STEP_SUM;
                state_next = ST_RND;
            end
            ST_RND: begin
                pc.step    = STEP_RND;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (k_reg == 4'(NSLOT - 1)) begin
                    state_next = ST_WB;
                end else begin
                    state_next = ST_LO;
                    k_next     = k_reg + 4'd1;
                    if (a_reg == 2'(NAXIS - 1)) begin
                        a_next = 2'd0;
                        b_next = b_reg + 2'd1;
                    end else begin
                        a_next = a_reg + 2'd1;
                    end
                end
            end
            ST_WB: begin
                state_next = ST_IDLE;
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            b_reg     <= 2'd0;
            a_reg     <= 2'd0;
            k_reg     <= 4'd0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            b_reg     <= b_next;
            a_reg     <= a_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
        end
    end

    // Word context captured at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg       <= win_slot;
            emit_total_reg <= (s_req_type == REQ_TOTAL);
            emit_win_reg   <= in_win && (s_req_type == REQ_ATOM);
        end
    end

    // Atom row: load from store, accumulate per slot
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RD) || ((state_reg == ST_NE) && (b_reg == 2'd0))) begin
            for (int i = 0; i < NSLOT; i++) begin
                row_reg[i] <= ram_rdata[i*VIR_W +: VIR_W];
            end
        end else if (state_reg == ST_ADD) begin
            row_reg[k_reg] <= sat_add(row_reg[k_reg], prod);
        end
    end

    // Total virial
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                total_reg[i] <= '0;
            end
        end else if (state_reg == ST_ADD) begin
            total_reg[k_reg] <= sat_add(total_reg[k_reg], prod);
        end
    end

    // Store port: clearing pass or row write-back
    always_comb begin
        for (int i = 0; i < NSLOT; i++) begin
            ram_wdata[i*VIR_W +: VIR_W] = (state_reg == ST_CLEAR) ? '0 : row_reg[i];
        end
    end
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : slot_reg;

    nva_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (win_slot),
        .rdata (ram_rdata)
    );

    nva_product u_product (
        .aclk            (aclk),
        .ctrl            (pc),
        .net_deriv_value (s_net_deriv_value),
        .env_x           (s_env_x),
        .env_y           (s_env_y),
        .env_z           (s_env_z),
        .rel_x           (s_rel_x),
        .rel_y           (s_rel_y),
        .rel_z           (s_rel_z),
        .prod            (prod)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            in_window_reg <= emit_win_reg;
            for (int i = 0; i < NSLOT; i++) begin
                vir_reg[i] <= emit_total_reg ? total_reg[i]
                            : (emit_win_reg ? row_reg[i] : '0);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_in_window = in_window_reg;
    assign m_vir_0     = vir_reg[0];
    assign m_vir_1     = vir_reg[1];
    assign m_vir_2     = vir_reg[2];
    assign m_vir_3     = vir_reg[3];
    assign m_vir_4     = vir_reg[4];
    assign m_vir_5     = vir_reg[5];
    assign m_vir_6     = vir_reg[6];
    assign m_vir_7     = vir_reg[7];
    assign m_vir_8     = vir_reg[8];

    // Checks
    `NVA_ASSERT_IMP(a_slot_index, state_reg == ST_ADD, k_reg == 4'(3 * b_reg + a_reg), "slot index out of step with axis counters")
    `NVA_ASSERT_IMP(a_wb_after_last, state_reg == ST_WB, ($past(state_reg) == ST_ADD) && ($past(k_reg) == 4'(NSLOT - 1)), "row write-back before last slot")
    `NVA_ASSERT_IMP(a_emit_source, $rose(m_valid_reg), $past(state_reg) == ST_EMIT, "result raised outside emit")

endmodule

`default_nettype wire

>>> tb/sv/nva_tb_pkg.sv
// Word types and the virial scoreboard with its own predicted sums for the accumulator testbench.
package nva_tb_pkg;
    import nva_pkg::*;

    // Codes the block has no name for
    localparam logic [1:0]           REQ_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd2;

    // One request word as driven on the input channel
    typedef struct packed {
        logic [1:0]         req;
        logic signed [16:0] idx;
        logic signed [31:0] net;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
    } nva_word_t;

    // One read result: window flag and nine Q32.32 sums, slot k at vir[k]
    typedef struct packed {
        logic                        in_win;
        logic [NSLOT-1:0][VIR_W-1:0] vir;
    } virial_result_t;

    class virial_scoreboard;
        logic [15:0]      win_start;
        logic [10:0]      win_count;
        logic [VIR_W-1:0] total_sum [NSLOT];
        logic [VIR_W-1:0] atom_sum [MAX_ATOMS][NSLOT];
        virial_result_t   expected_q [$];
        int               failures;
        int               results_seen;

        function new();
            win_start    = '0;
            win_count    = 11'd1024;
            failures     = 0;
            results_seen = 0;
            foreach (total_sum[k]) total_sum[k] = '0;
            foreach (atom_sum[i, k]) atom_sum[i][k] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_START: win_start = data;
                CFG_COUNT: win_count = data[10:0];
                default: ;
            endcase
        endfunction

        // Owned entries: the count register capped at the store depth
        function int eff_count();
            return (int'(win_count) > MAX_ATOMS) ? MAX_ATOMS : int'(win_count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit window_hit(logic signed [16:0] idx, output int slot);
            int off;
            slot = 0;
            if (idx < 0) return 1'b0;
            off = int'(idx) - int'(win_start);
            if (off < 0 || off >= eff_count()) return 1'b0;
            slot = off;
            return 1'b1;
        endfunction

        // Exact n*e*r in Q48.48, floor to Q32.32, clamp to 64 bits
        function logic [VIR_W-1:0] scaled_term(logic signed [31:0] n, logic signed [31:0] e,
                                               logic signed [31:0] r);
            logic signed [95:0] nw;
            logic signed [95:0] ew;
            logic signed [95:0] rw;
            logic signed [95:0] q;
            logic signed [95:0] hi_lim;
            logic signed [95:0] lo_lim;
            nw = n;
            ew = e;
            rw = r;
            hi_lim = {32'h0000_0000, VMAX};
            lo_lim = {32'hFFFF_FFFF, VMIN};
            q = (nw * ew * rw) >>> 16;
            if (q > hi_lim) return VMAX;
            if (q < lo_lim) return VMIN;
            return q[VIR_W-1:0];
        endfunction

        function logic [VIR_W-1:0] add_clamped(logic [VIR_W-1:0] x, logic [VIR_W-1:0] y);
            logic [VIR_W:0] s;
            s = {x[VIR_W-1], x} + {y[VIR_W-1], y};
            if (s[VIR_W] != s[VIR_W-1]) return s[VIR_W] ? VMIN : VMAX;
            return s[VIR_W-1:0];
        endfunction

        // Accepted input word: update predicted sums or queue the read result
        function void note_word(nva_word_t w);
            virial_result_t     res;
            int                 slot;
            bit                 hit;
            int                 k;
            logic [VIR_W-1:0]   p;
            logic signed [31:0] ev [NAXIS];
            logic signed [31:0] rv [NAXIS];
            hit = window_hit(w.idx, slot);
            ev[0] = w.ex;
            ev[1] = w.ey;
            ev[2] = w.ez;
            rv[0] = w.rx;
            rv[1] = w.ry;
            rv[2] = w.rz;
            res = '0;
            case (w.req)
                REQ_ACC: begin
                    if (hit) begin
                        for (int eb = 0; eb < NAXIS; eb++) begin
                            for (int ra = 0; ra < NAXIS; ra++) begin
                                k = NAXIS * eb + ra;
                                p = scaled_term(w.net, ev[eb], rv[ra]);
                                total_sum[k] = add_clamped(total_sum[k], p);
                                atom_sum[slot][k] = add_clamped(atom_sum[slot][k], p);
                            end
                        end
                    end
                end
                REQ_ATOM: begin
                    res.in_win = hit;
                    for (k = 0; k < NSLOT; k++) res.vir[k] = hit ? atom_sum[slot][k] : '0;
                    expected_q.push_back(res);
                end
                REQ_TOTAL: begin
                    for (k = 0; k < NSLOT; k++) res.vir[k] = total_sum[k];
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        // Accepted result word: compare with the oldest queued read
        function void check_result(virial_result_t got);
            virial_result_t want;
            int             bad_slot;
            bad_slot = -1;
            results_seen++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result word %0d arrived with no read outstanding", results_seen);
                return;
            end
            want = expected_q.pop_front();
            for (int k = NSLOT - 1; k >= 0; k--)
                if (got.vir[k] !== want.vir[k]) bad_slot = k;
            if (got.in_win !== want.in_win || bad_slot >= 0) begin
                failures++;
                if (failures <= 10) begin
                    if (bad_slot < 0) bad_slot = 0;
                    $display("result %0d: in_window exp %0b got %0b, vir_%0d exp %h got %h",
                             results_seen, want.in_win, got.in_win, bad_slot,
                             want.vir[bad_slot], got.vir[bad_slot]);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_neighbor_virial_accumulator_top.sv
// Testbench top: drives request words and config writes, checks read results against predicted sums.
module tb_neighbor_virial_accumulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nva_pkg::*;
    import nva_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_GAP        = 17;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index         = CFG_START;
    logic [15:0]           cfg_wdata         = '0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type        = REQ_ACC;
    logic signed [16:0]    s_neighbor_index  = '0;
    logic signed [31:0]    s_net_deriv_value = '0;
    logic signed [31:0]    s_env_x           = '0;
    logic signed [31:0]    s_env_y           = '0;
    logic signed [31:0]    s_env_z           = '0;
    logic signed [31:0]    s_rel_x           = '0;
    logic signed [31:0]    s_rel_y           = '0;
    logic signed [31:0]    s_rel_z           = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic                  m_in_window;
    logic signed [63:0]    m_vir_0, m_vir_1, m_vir_2, m_vir_3, m_vir_4;
    logic signed [63:0]    m_vir_5, m_vir_6, m_vir_7, m_vir_8;

    virial_scoreboard sb;
    bit               send_gaps    = 1'b1;
    bit               take_gaps    = 1'b1;
    int               quiet_cycles = 0;

    neighbor_virial_accumulator_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_neighbor_index  (s_neighbor_index),
        .s_net_deriv_value (s_net_deriv_value),
        .s_env_x           (s_env_x),
        .s_env_y           (s_env_y),
        .s_env_z           (s_env_z),
        .s_rel_x           (s_rel_x),
        .s_rel_y           (s_rel_y),
        .s_rel_z           (s_rel_z),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_in_window       (m_in_window),
        .m_vir_0           (m_vir_0),
        .m_vir_1           (m_vir_1),
        .m_vir_2           (m_vir_2),
        .m_vir_3           (m_vir_3),
        .m_vir_4           (m_vir_4),
        .m_vir_5           (m_vir_5),
        .m_vir_6           (m_vir_6),
        .m_vir_7           (m_vir_7),
        .m_vir_8           (m_vir_8)
    );

    always #5 aclk = ~aclk;

    // Watchdog: cycles without any handshake or config write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic nva_word_t word_of(logic [1:0] req, logic signed [16:0] idx,
                                          logic signed [31:0] net, logic signed [31:0] ex,
                                          logic signed [31:0] ey, logic signed [31:0] ez,
                                          logic signed [31:0] rx, logic signed [31:0] ry,
                                          logic signed [31:0] rz);
        nva_word_t w;
        w.req = req;
        w.idx = idx;
        w.net = net;
        w.ex  = ex;
        w.ey  = ey;
        w.ez  = ez;
        w.rx  = rx;
        w.ry  = ry;
        w.rz  = rz;
        return w;
    endfunction

    // Q16.16 operand: mostly realistic magnitudes, some full range and edge values
    function automatic logic signed [31:0] rand_q16();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return int'($urandom_range(0, 262143)) - 131072;
        if (sel < 7) return $urandom;
        if (sel == 7) return int'($urandom_range(0, 33554431)) - 16777216;
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return Q_ONE;
        endcase
    endfunction

    // Neighbor index inside the current window (hot slots half the time) or outside it
    function automatic logic signed [16:0] pick_index(bit want_in);
        int start_v;
        int cnt;
        int span;
        int v;
        start_v = int'(sb.win_start);
        cnt     = sb.eff_count();
        span    = (start_v + cnt > 65536) ? 65536 - start_v : cnt;
        if (want_in && span > 0) begin
            if ($urandom_range(0, 1))
                v = start_v + int'($urandom_range(0, (span > 8) ? 7 : span - 1));
            else
                v = start_v + int'($urandom_range(0, span - 1));
            return v[16:0];
        end
        case ($urandom_range(0, 4))
            0: v = -1;
            1: v = -int'($urandom_range(1, 65536));
            2: v = start_v - 1;
            3: v = start_v + cnt;
            default: v = int'($urandom_range(0, 131071));
        endcase
        return v[16:0];
    endfunction

    function automatic nva_word_t random_word();
        nva_word_t w;
        int        pick;
        w.net = rand_q16();
        w.ex  = rand_q16();
        w.ey  = rand_q16();
        w.ez  = rand_q16();
        w.rx  = rand_q16();
        w.ry  = rand_q16();
        w.rz  = rand_q16();
        pick  = $urandom_range(0, 99);
        if (pick < 55) begin
            w.req = REQ_ACC;
            w.idx = pick_index($urandom_range(0, 9) != 0);
        end else if (pick < 78) begin
            w.req = REQ_ATOM;
            w.idx = pick_index($urandom_range(0, 4) != 0);
        end else if (pick < 90) begin
            w.req = REQ_TOTAL;
            w.idx = pick_index($urandom_range(0, 1) != 0);
        end else if (pick < 95) begin
            w.req = REQ_ACC;
            w.idx = pick_index(1'b0);
        end else begin
            w.req = REQ_IGNORED;
            w.idx = pick_index($urandom_range(0, 1) != 0);
        end
        return w;
    endfunction

    // Drive one input word after a random gap and wait for its handshake
    task automatic send_word(nva_word_t w);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type        = w.req;
        s_neighbor_index  = w.idx;
        s_net_deriv_value = w.net;
        s_env_x           = w.ex;
        s_env_y           = w.ey;
        s_env_z           = w.ez;
        s_rel_x           = w.rx;
        s_rel_y           = w.ry;
        s_rel_z           = w.rz;
        s_valid           = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Wait for every queued read, then let a skipped or in-flight accumulate finish
    task automatic settle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random(int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            if (i % 50 == 0) send_gaps = ($urandom_range(0, 3) != 0);
            send_word(random_word());
        end
    endtask

    task automatic run_phase(logic [15:0] start_v, logic [15:0] count_v, int n_items);
        settle();
        write_reg(CFG_START, start_v);
        write_reg(CFG_COUNT, count_v);
        write_reg(CFG_SPARE, 16'($urandom));
        run_random(n_items);
    endtask

    // Result side: random stall before each word, idle-free stretches now and then
    initial begin
        virial_result_t got;
        int             n_taken;
        int             stall;
        n_taken = 0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (n_taken % 32 == 0) take_gaps = ($urandom_range(0, 3) != 0);
            stall = take_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.in_win = m_in_window;
            got.vir    = {m_vir_8, m_vir_7, m_vir_6, m_vir_5, m_vir_4,
                          m_vir_3, m_vir_2, m_vir_1, m_vir_0};
            sb.check_result(got);
            n_taken++;
            @(negedge aclk);
            m_ready = 1'b0;
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words under the reset window (start 0, 1024 entries)
        send_word(word_of(REQ_TOTAL, 17'sd0, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd0, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd1023, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd1024, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, -17'sd1, '0, '0, '0, '0, '0, '0, '0));
        // saturating products of both signs, zero and tiny terms
        send_word(word_of(REQ_ACC, 17'sd5, Q_MAX, Q_MIN, Q_MAX, '0, Q_MIN, Q_MAX, 32'sd1));
        // same again: accumulators pin at the limits
        send_word(word_of(REQ_ACC, 17'sd5, Q_MAX, Q_MIN, Q_MAX, '0, Q_MIN, Q_MAX, 32'sd1));
        send_word(word_of(REQ_ACC, 17'sd5, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_word(word_of(REQ_ATOM, 17'sd5, '0, '0, '0, '0, '0, '0, '0));
        // sub-LSB products among the terms: negative ones floor to -1, positive ones to 0
        send_word(word_of(REQ_ACC, 17'sd7, 32'sd1, 32'sd1, -32'sd1, Q_ONE, -32'sd1, 32'sd1,
                          Q_ONE));
        send_word(word_of(REQ_ACC, 17'sd7, Q_ONE, -Q_ONE, Q_ONE, 32'sd3, Q_ONE, -32'sd5,
                          Q_MAX));
        // skipped accumulates: index -1, most negative index, just past the window
        send_word(word_of(REQ_ACC, -17'sd1, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_word(word_of(REQ_ACC, 17'sh10000, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE));
        send_word(word_of(REQ_ACC, 17'sd1024, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE));
        send_word(word_of(REQ_IGNORED, 17'sd7, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                          Q_ONE));
        send_word(word_of(REQ_ACC, 17'sd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_word(word_of(REQ_ACC, 17'sd1023, Q_MIN, 32'sd1, -32'sd1, Q_MAX, Q_ONE, -Q_ONE,
                          '0));
        send_word(word_of(REQ_ATOM, 17'sd7, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd0, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd1023, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_TOTAL, -17'sd1, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_ATOM, 17'sd65535, '0, '0, '0, '0, '0, '0, '0));
        send_word(word_of(REQ_IGNORED, -17'sd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                          Q_MAX));

        // Random phases over several windows, extremes included
        run_phase(16'hFFFF, 16'd1, 200);
        run_phase(16'd0, 16'd0, 100);
        run_phase(16'd1000, 16'hFFFF, 300);
        run_phase(16'd64000, 16'd1024, 250);
        run_phase(16'd3, 16'd17, 250);
        run_phase(16'd0, 16'd1024, 250);

        settle();
        if (sb.pending() != 0)
            $display("%0d read results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
